[rtl/tmrm_pkg.sv]
// Shared types and constants for the transceiver management read mux.
// Holds the decoded operation format passed from the front end to the back end.
// No dependencies.
package tmrm_pkg;

	localparam logic [7:0] DOM_FIRST     = 8'd96;
	localparam logic [7:0] DOM_LAST      = 8'd105;
	localparam int         SNAP_DEPTH    = 10;
	localparam int         SNAP_AW       = $clog2(SNAP_DEPTH);

	localparam logic [7:0] PW_FIRST      = 8'h78;
	localparam logic [7:0] PW_LAST       = 8'h7E;
	localparam int         PW_LEN        = 7;
	localparam int         PW_AW         = $clog2(PW_LEN);
	localparam logic [7:0] PW_BYTES [PW_LEN] = '{8'h43, 8'h49, 8'h47, 8'h2D, 8'h53, 8'h46, 8'h50};

	localparam logic [7:0] PAGE_SEL_ADDR = 8'h7F;
	localparam logic [7:0] PAGE_00       = 8'h00;
	localparam logic [7:0] PAGE_01       = 8'h01;
	localparam logic [7:0] PAGE_02       = 8'h02;
	localparam logic [7:0] PAGE_80       = 8'h80;
	localparam logic [7:0] BYTE_FF       = 8'hFF;

	localparam int         ID_DEPTH      = 256;
	localparam int         PAGE_DEPTH    = 128;
	localparam int         PAGE_AW       = $clog2(PAGE_DEPTH);

	// write targets, also bit positions in op_t.wr_en
	localparam int         NUM_TABLES    = 6;
	localparam logic [2:0] TSEL_ID       = 3'd0;
	localparam logic [2:0] TSEL_LOWER    = 3'd1;
	localparam logic [2:0] TSEL_P00      = 3'd2;
	localparam logic [2:0] TSEL_P02      = 3'd3;
	localparam logic [2:0] TSEL_P80      = 3'd4;
	localparam logic [2:0] TSEL_DOM      = 3'd5;

	localparam int         QDEPTH        = 2;
	localparam int         QPTR_W        = $clog2(QDEPTH);
	localparam int         QCNT_W        = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		K_WRITE   = 3'd0,
		K_ID      = 3'd1,
		K_DOM     = 3'd2,
		K_ZERO    = 3'd3,
		K_PAGESEL = 3'd4,
		K_LOWER   = 3'd5,
		K_UPPER   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		SRC_ZERO  = 3'd0,
		SRC_FF    = 3'd1,
		SRC_ID    = 3'd2,
		SRC_LOWER = 3'd3,
		SRC_P00   = 3'd4,
		SRC_P02   = 3'd5,
		SRC_P80   = 3'd6,
		SRC_SNAP  = 3'd7
	} src_t;

	typedef struct packed {
		kind_t                 kind;
		logic [NUM_TABLES-1:0] wr_en;
		logic                  locked;
		logic                  sd;
		logic [7:0]            addr;
		logic [7:0]            data;
	} op_t;

endpackage

[rtl/tmrm_front.sv]
// Front end: takes input items, holds the offset limit, classifies each item.
// Depends on tmrm_pkg; feeds tmrm_queue.
module tmrm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             func,
	input  logic             is_a0,
	input  logic [7:0]       reg_addr,
	input  logic [2:0]       table_sel,
	input  logic [7:0]       write_data,
	input  logic             dom_locked,
	input  logic             offset_limit_we,
	input  logic [7:0]       offset_limit_wdata,
	output logic             q_push,
	output tmrm_pkg::op_t    q_data,
	input  logic             q_full
);
	import tmrm_pkg::*;

	logic [7:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 8'hFF;
		end else if (offset_limit_we) begin
			limit_q <= offset_limit_wdata;
		end
	end

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_data        = '0;
		q_data.kind   = K_LOWER;
		q_data.addr   = reg_addr;
		q_data.data   = write_data;
		q_data.locked = dom_locked;
		q_data.sd     = !func && (reg_addr > limit_q);
		if (func) begin
			q_data.kind = K_WRITE;
			unique case (table_sel)
				TSEL_ID:    q_data.wr_en[TSEL_ID]    = 1'b1;
				TSEL_LOWER: q_data.wr_en[TSEL_LOWER] = !reg_addr[7];
				TSEL_P00:   q_data.wr_en[TSEL_P00]   = !reg_addr[7];
				TSEL_P02:   q_data.wr_en[TSEL_P02]   = !reg_addr[7];
				TSEL_P80:   q_data.wr_en[TSEL_P80]   = !reg_addr[7];
				TSEL_DOM:   q_data.wr_en[TSEL_DOM]   = (reg_addr < 8'(SNAP_DEPTH));
				default:    q_data.wr_en             = '0;
			endcase
		end else begin
			priority if (is_a0) begin
				q_data.kind = K_ID;
			end else if (reg_addr[7]) begin
				q_data.kind = K_UPPER;
			end else if (reg_addr >= DOM_FIRST && reg_addr <= DOM_LAST) begin
				q_data.kind = K_DOM;
			end else if (reg_addr >= PW_FIRST && reg_addr <= PW_LAST) begin
				q_data.kind = K_ZERO;
			end else if (reg_addr == PAGE_SEL_ADDR) begin
				q_data.kind = K_PAGESEL;
			end else begin
				q_data.kind = K_LOWER;
			end
		end
	end

endmodule

[rtl/tmrm_queue.sv]
// Short queue of decoded operations between the front end and the back end.
// Depends on tmrm_pkg.
module tmrm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tmrm_pkg::op_t wr_data,
	output logic          full,
	input  logic          rd,
	output tmrm_pkg::op_t rd_data,
	output logic          not_empty
);
	import tmrm_pkg::*;

	op_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/tmrm_back.sv]
// Back end: owns the tables and the password/snapshot state, runs operations
// in order and holds the result register. Depends on tmrm_pkg.
module tmrm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  tmrm_pkg::op_t q_data,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    read_data,
	output logic          slave_disable
);
	import tmrm_pkg::*;

	logic [7:0] id_mem    [ID_DEPTH];
	logic [7:0] lower_mem [PAGE_DEPTH];
	logic [7:0] p00_mem   [PAGE_DEPTH];
	logic [7:0] p02_mem   [PAGE_DEPTH];
	logic [7:0] p80_mem   [PAGE_DEPTH];
	logic [7:0] snap_q    [SNAP_DEPTH];

	logic [PW_LEN-1:0] pw_match_q;
	logic              pending_q;
	logic [7:0]        page_q;

	logic       valid_s1;
	src_t       src_s1;
	logic       sd_s1;
	logic [7:0] id_rd_s1;
	logic [7:0] lower_rd_s1;
	logic [7:0] p00_rd_s1;
	logic [7:0] p02_rd_s1;
	logic [7:0] p80_rd_s1;
	logic [7:0] snap_rd_s1;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_sd_q;

	logic             advance;
	logic             issue;
	logic             pw_ok;
	src_t             src;
	logic [PAGE_AW-1:0] page_idx;
	logic [7:0]       snap_off;
	logic [PW_AW-1:0] pw_idx;
	logic [7:0]       result;

	assign advance  = valid_s1 && (!out_valid_q || pop);
	assign issue    = q_valid && (!valid_s1 || advance);
	assign q_pop    = issue;
	assign pw_ok    = &pw_match_q;
	assign page_idx = q_data.addr[PAGE_AW-1:0];
	assign snap_off = q_data.addr - DOM_FIRST;
	assign pw_idx   = PW_AW'(q_data.addr - PW_FIRST);

	always_comb begin
		unique case (q_data.kind)
			K_WRITE:   src = SRC_ZERO;
			K_ID:      src = SRC_ID;
			K_DOM:     src = (q_data.locked || pending_q) ? SRC_SNAP : SRC_LOWER;
			K_ZERO:    src = SRC_ZERO;
			K_PAGESEL: src = pw_ok ? SRC_LOWER : SRC_ZERO;
			K_LOWER:   src = SRC_LOWER;
			K_UPPER: begin
				priority if (page_q == PAGE_00 || page_q == PAGE_01) begin
					src = SRC_P00;
				end else if (page_q == PAGE_02 && pw_ok) begin
					src = SRC_P02;
				end else if (page_q == PAGE_80 && pw_ok) begin
					src = SRC_P80;
				end else begin
					src = SRC_FF;
				end
			end
			default:   src = SRC_ZERO;
		endcase
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (issue) begin
			if (q_data.wr_en[TSEL_ID]) begin
				id_mem[q_data.addr] <= q_data.data;
			end
			if (q_data.wr_en[TSEL_LOWER]) begin
				lower_mem[page_idx] <= q_data.data;
			end
			if (q_data.wr_en[TSEL_P00]) begin
				p00_mem[page_idx] <= q_data.data;
			end
			if (q_data.wr_en[TSEL_P02]) begin
				p02_mem[page_idx] <= q_data.data;
			end
			if (q_data.wr_en[TSEL_P80]) begin
				p80_mem[page_idx] <= q_data.data;
			end
			id_rd_s1    <= id_mem[q_data.addr];
			lower_rd_s1 <= lower_mem[page_idx];
			p00_rd_s1   <= p00_mem[page_idx];
			p02_rd_s1   <= p02_mem[page_idx];
			p80_rd_s1   <= p80_mem[page_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (q_data.wr_en[TSEL_DOM]) begin
				snap_q[q_data.addr[SNAP_AW-1:0]] <= q_data.data;
			end
			if (snap_off < 8'(SNAP_DEPTH)) begin
				snap_rd_s1 <= snap_q[snap_off[SNAP_AW-1:0]];
			end else begin
				snap_rd_s1 <= '0;
			end
			// shadow of the page-select byte so upper reads need no second lower port
			if (q_data.wr_en[TSEL_LOWER] && q_data.addr == PAGE_SEL_ADDR) begin
				page_q <= q_data.data;
			end
			src_s1 <= src;
			sd_s1  <= q_data.sd;
		end
		if (advance) begin
			out_data_q <= result;
			out_sd_q   <= sd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_match_q  <= '0;
			pending_q   <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (q_data.wr_en[TSEL_LOWER] && q_data.addr >= PW_FIRST
				    && q_data.addr <= PW_LAST) begin
					pw_match_q[pw_idx] <= (q_data.data == PW_BYTES[pw_idx]);
				end
				if (q_data.kind == K_DOM) begin
					if (q_data.locked) begin
						pending_q <= 1'b1;
					end else if (pending_q) begin
						pending_q <= 1'b0;
					end
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (src_s1)
			SRC_ZERO:  result = '0;
			SRC_FF:    result = BYTE_FF;
			SRC_ID:    result = id_rd_s1;
			SRC_LOWER: result = lower_rd_s1;
			SRC_P00:   result = p00_rd_s1;
			SRC_P02:   result = p02_rd_s1;
			SRC_P80:   result = p80_rd_s1;
			SRC_SNAP:  result = snap_rd_s1;
		endcase
	end

	assign empty         = !out_valid_q;
	assign read_data     = out_data_q;
	assign slave_disable = out_sd_q;

endmodule

[rtl/transceiver_mgmt_read_mux.sv]
// Top level of the transceiver management read mux: front end, op queue, back end.
// Depends on tmrm_pkg, tmrm_front, tmrm_queue and tmrm_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   input    | push / full         | func, is_a0, reg_addr, table_sel, write_data,
//            |                     | dom_locked
//   result   | empty / pop         | read_data, slave_disable
//   config   | offset_limit_we     | offset_limit_wdata
//
// An accepted item passes through the op queue slot, the registered table read and
// then the result register. Items run in order through the back end, one per cycle
// when the result side keeps up.
// Reset clears the queue, the result register, the password match and the
// snapshot flag; table contents are undefined until written.
// A stalled result holds the back end; once the queue fills, full rises.
module transceiver_mgmt_read_mux (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic       is_a0,
	input  logic [7:0] reg_addr,
	input  logic [2:0] table_sel,
	input  logic [7:0] write_data,
	input  logic       dom_locked,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] read_data,
	output logic       slave_disable,
	input  logic       offset_limit_we,
	input  logic [7:0] offset_limit_wdata
);
	import tmrm_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	op_t  q_in;
	op_t  q_out;

	tmrm_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.func               (func),
		.is_a0              (is_a0),
		.reg_addr           (reg_addr),
		.table_sel          (table_sel),
		.write_data         (write_data),
		.dom_locked         (dom_locked),
		.offset_limit_we    (offset_limit_we),
		.offset_limit_wdata (offset_limit_wdata),
		.q_push             (q_push),
		.q_data             (q_in),
		.q_full             (q_full)
	);

	tmrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_push),
		.wr_data   (q_in),
		.full      (q_full),
		.rd        (q_pop),
		.rd_data   (q_out),
		.not_empty (q_not_empty)
	);

	tmrm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_not_empty),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.read_data     (read_data),
		.slave_disable (slave_disable)
	);

endmodule

[rtl/tmrm_checker.sv]
// Port-level checks for transceiver_mgmt_read_mux, attached by bind.
// Depends on nothing but the top level's ports.
module tmrm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] read_data,
	input logic       slave_disable
);

	// reset leaves nothing to transfer and room to accept
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("result or full asserted during reset");

	// a waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(read_data) && $stable(slave_disable))
		else $error("waiting result changed before transfer");

	// the queue fills only while the result side is stalled
	a_full_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input stalled with no result waiting");

	// full rises only after an input transfer
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind transceiver_mgmt_read_mux tmrm_checker u_tmrm_checker (.*);

[bench/tb_transceiver_mgmt_read_mux.sv]
// Self-checking bench for transceiver_mgmt_read_mux: directed and random item streams,
// with a behavioral copy of the management map that predicts every reply.
// Depends on tmrm_pkg and the transceiver_mgmt_read_mux RTL.
module tb_transceiver_mgmt_read_mux;
	timeunit 1ns;
	timeprecision 1ps;

	import tmrm_pkg::*;

	localparam logic       FUNC_READ    = 1'b0;
	localparam logic       FUNC_WRITE   = 1'b1;
	localparam logic [2:0] TSEL_NONE    = 3'd7;
	localparam logic [7:0] UPPER_BASE   = 8'h80;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         STUCK_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 2;

	typedef struct packed {
		logic       func;
		logic       is_a0;
		logic [7:0] addr;
		logic [2:0] sel;
		logic [7:0] data;
		logic       locked;
	} mgmt_req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       sd;
	} mgmt_reply_t;

	logic       clk                = 1'b0;
	logic       arst_n             = 1'b1;
	logic       push               = 1'b0;
	logic       full;
	logic       func               = 1'b0;
	logic       is_a0              = 1'b0;
	logic [7:0] reg_addr           = 8'h00;
	logic [2:0] table_sel          = 3'd0;
	logic [7:0] write_data         = 8'h00;
	logic       dom_locked         = 1'b0;
	logic       empty;
	logic       pop                = 1'b0;
	logic [7:0] read_data;
	logic       slave_disable;
	logic       offset_limit_we    = 1'b0;
	logic [7:0] offset_limit_wdata = 8'h00;

	// shadow of the map, indexed by the source that serves a byte
	logic [7:0]        shadow [8][256];
	bit                filled [8][256];
	logic              snap_pend = 1'b0;
	logic [PW_LEN-1:0] pw_hits   = '0;
	logic [7:0]        limit_q   = 8'hFF;

	mgmt_reply_t replies_due [$];
	int          fails         = 0;
	int          send_idle_pct = 0;
	int          pop_idle_pct  = 0;
	int          stuck_cycles  = 0;
	logic        holding       = 1'b0;
	event        hold_results;

	transceiver_mgmt_read_mux dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.func               (func),
		.is_a0              (is_a0),
		.reg_addr           (reg_addr),
		.table_sel          (table_sel),
		.write_data         (write_data),
		.dom_locked         (dom_locked),
		.empty              (empty),
		.pop                (pop),
		.read_data          (read_data),
		.slave_disable      (slave_disable),
		.offset_limit_we    (offset_limit_we),
		.offset_limit_wdata (offset_limit_wdata)
	);

	always #2 clk = ~clk;

	// Which source serves a read and at which index; no state changes here.
	function automatic src_t locate(input mgmt_req_t r, output int idx);
		logic [7:0] page;
		idx = int'(r.addr);
		if (r.is_a0)
			return SRC_ID;
		if (r.addr < UPPER_BASE) begin
			if (r.addr >= DOM_FIRST && r.addr <= DOM_LAST) begin
				if (!(r.locked || snap_pend))
					return SRC_LOWER;
				idx = int'(r.addr - DOM_FIRST);
				return (idx < SNAP_DEPTH) ? SRC_SNAP : SRC_ZERO;
			end
			if (r.addr >= PW_FIRST && r.addr <= PW_LAST)
				return SRC_ZERO;
			if (r.addr == PAGE_SEL_ADDR && !(&pw_hits))
				return SRC_ZERO;
			return SRC_LOWER;
		end
		// upper half depends on the page select; point at it while unwritten
		idx = int'(PAGE_SEL_ADDR);
		if (!filled[SRC_LOWER][PAGE_SEL_ADDR])
			return SRC_LOWER;
		page = shadow[SRC_LOWER][PAGE_SEL_ADDR];
		idx = int'(r.addr - UPPER_BASE);
		if (page == PAGE_00 || page == PAGE_01)
			return SRC_P00;
		if (page == PAGE_02 && (&pw_hits))
			return SRC_P02;
		if (page == PAGE_80 && (&pw_hits))
			return SRC_P80;
		return SRC_FF;
	endfunction

	// Table hit by a write; false when the write is dropped.
	function automatic logic write_target(input mgmt_req_t r, output src_t s);
		int depth;
		depth = 0;
		s = SRC_ZERO;
		case (r.sel)
			TSEL_ID:    begin s = SRC_ID;    depth = ID_DEPTH;   end
			TSEL_LOWER: begin s = SRC_LOWER; depth = PAGE_DEPTH; end
			TSEL_P00:   begin s = SRC_P00;   depth = PAGE_DEPTH; end
			TSEL_P02:   begin s = SRC_P02;   depth = PAGE_DEPTH; end
			TSEL_P80:   begin s = SRC_P80;   depth = PAGE_DEPTH; end
			TSEL_DOM:   begin s = SRC_SNAP;  depth = SNAP_DEPTH; end
			default:    ;
		endcase
		return int'(r.addr) < depth;
	endfunction

	function automatic mgmt_reply_t predict_reply(input mgmt_req_t r);
		mgmt_reply_t e;
		src_t        s;
		int          idx;
		e = '0;
		if (r.func == FUNC_WRITE) begin
			if (write_target(r, s)) begin
				shadow[s][r.addr] = r.data;
				filled[s][r.addr] = 1'b1;
				if (s == SRC_LOWER && r.addr >= PW_FIRST && r.addr <= PW_LAST)
					pw_hits[r.addr - PW_FIRST] = (r.data == PW_BYTES[r.addr - PW_FIRST]);
			end
			return e;
		end
		s = locate(r, idx);
		case (s)
			SRC_ZERO: e.rdata = 8'h00;
			SRC_FF:   e.rdata = BYTE_FF;
			default:  e.rdata = shadow[s][idx];
		endcase
		// snapshot flag follows the lock on every diagnostic read of the window
		if (!r.is_a0 && r.addr >= DOM_FIRST && r.addr <= DOM_LAST)
			snap_pend = r.locked;
		e.sd = r.addr > limit_q;
		return e;
	endfunction

	function automatic mgmt_req_t mk_write(input logic [2:0] sel, input logic [7:0] idx,
			input logic [7:0] data);
		mgmt_req_t r;
		r.func   = FUNC_WRITE;
		r.is_a0  = 1'($urandom);
		r.addr   = idx;
		r.sel    = sel;
		r.data   = data;
		r.locked = 1'($urandom);
		return r;
	endfunction

	function automatic mgmt_req_t mk_read(input logic a0, input logic [7:0] addr,
			input logic locked);
		mgmt_req_t r;
		r.func   = FUNC_READ;
		r.is_a0  = a0;
		r.addr   = addr;
		r.sel    = 3'($urandom);
		r.data   = 8'($urandom);
		r.locked = locked;
		return r;
	endfunction

	// Mostly reads of written bytes and writes that fill the map, plus dropped writes.
	function automatic mgmt_req_t pick_request();
		mgmt_req_t r;
		src_t      s;
		int        idx;
		int        roll;
		r.func   = FUNC_READ;
		r.is_a0  = 1'($urandom);
		r.addr   = 8'($urandom);
		r.sel    = 3'($urandom);
		r.data   = 8'($urandom);
		r.locked = 1'($urandom);
		if ($urandom_range(99) < 35) begin
			r.func = FUNC_WRITE;
			if ($urandom_range(99) >= 5)
				r.sel = 3'($urandom_range(TSEL_DOM));
			if (r.sel == TSEL_DOM && $urandom_range(99) < 90)
				r.addr = 8'($urandom_range(SNAP_DEPTH - 1));
			else if (r.sel != TSEL_ID && $urandom_range(99) < 90)
				r.addr = 8'($urandom_range(PAGE_DEPTH - 1));
			if (r.sel == TSEL_LOWER && $urandom_range(99) < 20)
				r.addr = 8'($urandom_range(PAGE_SEL_ADDR, PW_FIRST));
		end else begin
			roll = $urandom_range(99);
			r.is_a0 = (roll < 25);
			if (roll >= 25 && roll < 50)
				r.addr = 8'($urandom_range(DOM_LAST, DOM_FIRST));
			else if (roll >= 50 && roll < 60)
				r.addr = 8'($urandom_range(PAGE_SEL_ADDR, PW_FIRST));
			else if (roll >= 60 && roll < 75)
				r.addr = 8'(UPPER_BASE + $urandom_range(15));
			s = locate(r, idx);
			if (s != SRC_ZERO && s != SRC_FF && !filled[s][idx]) begin
				// fill the byte this read would reach instead
				r.func = FUNC_WRITE;
				r.addr = 8'(idx);
				case (s)
					SRC_ID:   r.sel = TSEL_ID;
					SRC_P00:  r.sel = TSEL_P00;
					SRC_P02:  r.sel = TSEL_P02;
					SRC_P80:  r.sel = TSEL_P80;
					SRC_SNAP: r.sel = TSEL_DOM;
					default:  r.sel = TSEL_LOWER;
				endcase
			end
		end
		if (r.func == FUNC_WRITE && r.sel == TSEL_LOWER) begin
			if (r.addr >= PW_FIRST && r.addr <= PW_LAST && $urandom_range(99) < 75)
				r.data = PW_BYTES[r.addr - PW_FIRST];
			else if (r.addr == PAGE_SEL_ADDR) begin
				case ($urandom_range(4))
					0:       r.data = PAGE_00;
					1:       r.data = PAGE_01;
					2:       r.data = PAGE_02;
					3:       r.data = PAGE_80;
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	task automatic send_item(input mgmt_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		func       <= r.func;
		is_a0      <= r.is_a0;
		reg_addr   <= r.addr;
		table_sel  <= r.sel;
		write_data <= r.data;
		dom_locked <= r.locked;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		replies_due.push_back(predict_reply(r));
	endtask

	// Drop push and let every outstanding reply drain.
	task automatic wait_idle();
		push <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_offset_limit(input logic [7:0] v);
		offset_limit_we    <= 1'b1;
		offset_limit_wdata <= v;
		@(posedge clk);
		offset_limit_we <= 1'b0;
		limit_q = v;
	endtask

	task automatic test_id_extremes();
		send_item(mk_write(TSEL_ID, 8'h00, 8'h00));
		send_item(mk_write(TSEL_ID, 8'hFF, 8'hFF));
		send_item(mk_read(1'b1, 8'h00, 1'b0));
		send_item(mk_read(1'b1, 8'hFF, 1'b1));
	endtask

	task automatic test_password_pages();
		send_item(mk_write(TSEL_LOWER, PAGE_SEL_ADDR, PAGE_02));
		send_item(mk_write(TSEL_P02, 8'h7F, 8'hA5));
		// page 2 stays hidden until the password matches
		send_item(mk_read(1'b0, 8'hFF, 1'b0));
		for (int i = 0; i < PW_LEN; i++)
			send_item(mk_write(TSEL_LOWER, 8'(PW_FIRST + i), PW_BYTES[i]));
		send_item(mk_read(1'b0, 8'hFF, 1'b0));
		send_item(mk_read(1'b0, PAGE_SEL_ADDR, 1'b0));
		send_item(mk_read(1'b0, PW_LAST, 1'b1));
	endtask

	task automatic test_dom_snapshot();
		send_item(mk_write(TSEL_DOM, 8'(SNAP_DEPTH - 1), 8'h5A));
		send_item(mk_write(TSEL_LOWER, DOM_LAST, 8'h11));
		send_item(mk_read(1'b0, DOM_LAST, 1'b1));
		send_item(mk_read(1'b0, DOM_LAST, 1'b0));
		send_item(mk_read(1'b0, DOM_LAST, 1'b0));
	endtask

	task automatic test_ignored_writes();
		send_item(mk_write(TSEL_NONE, 8'h00, 8'hC3));
		send_item(mk_write(TSEL_DOM, 8'(SNAP_DEPTH), 8'h3C));
		send_item(mk_write(TSEL_LOWER, 8'hFF, 8'h33));
		// page select and page 2 must be untouched
		send_item(mk_read(1'b0, PAGE_SEL_ADDR, 1'b0));
		send_item(mk_read(1'b0, 8'hFF, 1'b0));
	endtask

	task automatic test_offset_limit();
		wait_idle();
		set_offset_limit(8'h00);
		send_item(mk_read(1'b1, 8'h00, 1'b0));
		send_item(mk_read(1'b1, 8'hFF, 1'b0));
		send_item(mk_read(1'b0, PW_LAST, 1'b0));
		wait_idle();
		set_offset_limit(8'hFF);
	endtask

	task automatic test_result_backpressure();
		wait_idle();
		-> hold_results;
		repeat (40) send_item(pick_request());
		wait_idle();
	endtask

	task automatic test_random_traffic(input int total);
		mgmt_req_t r;
		src_t      s;
		int        done;
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0:       begin send_idle_pct = 37; pop_idle_pct = 63; end
				1:       begin send_idle_pct = 63; pop_idle_pct = 37; end
				default: begin send_idle_pct = 0;  pop_idle_pct = 0;  end
			endcase
			for (int k = 0; k < 4; k++) begin
				wait_idle();
				case (k)
					0:       set_offset_limit(8'h00);
					1:       set_offset_limit(8'hFF);
					2:       set_offset_limit(8'h7F);
					default: set_offset_limit(8'($urandom));
				endcase
				done = 0;
				while (done < total / 12) begin
					r = pick_request();
					// dropped writes do not count
					if (r.func == FUNC_READ || write_target(r, s))
						done++;
					send_item(r);
				end
			end
		end
		wait_idle();
	endtask

	// Check each reply transfer against the oldest prediction.
	always @(posedge clk) begin : check_replies
		mgmt_reply_t e;
		if (pop === 1'b1 && empty === 1'b0) begin
			if (replies_due.size() == 0) begin
				$error("reply with nothing outstanding: read_data %02h slave_disable %0b",
					read_data, slave_disable);
				fails++;
			end else begin
				e = replies_due.pop_front();
				if (read_data !== e.rdata) begin
					$error("read_data expected %02h actual %02h", e.rdata, read_data);
					fails++;
				end
				if (slave_disable !== e.sd) begin
					$error("slave_disable expected %0b actual %0b", e.sd, slave_disable);
					fails++;
				end
			end
		end
		pop <= !holding && ($urandom_range(99) >= pop_idle_pct);
	end

	initial forever begin
		@(hold_results);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$error("no transfer for %0d cycles", STUCK_LIMIT);
		$display("FAIL transceiver_mgmt_read_mux");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		send_idle_pct = 37;
		pop_idle_pct  = 63;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_id_extremes();
		test_password_pages();
		test_dom_snapshot();
		test_ignored_writes();
		test_offset_limit();
		test_result_backpressure();
		test_random_traffic(1900);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASS transceiver_mgmt_read_mux");
		else
			$display("FAIL transceiver_mgmt_read_mux");
		$finish;
	end

endmodule

[filelist.f]
rtl/tmrm_pkg.sv
rtl/tmrm_front.sv
rtl/tmrm_queue.sv
rtl/tmrm_back.sv
rtl/transceiver_mgmt_read_mux.sv
rtl/tmrm_checker.sv
bench/tb_transceiver_mgmt_read_mux.sv
